/* hw/rtl/smt_pkg.sv */
// Shared types and constants for the sorted multiset table.
// Used by smt_front, smt_back, smt_rsp_q and sorted_multiset_table_top.
package smt_pkg;

    localparam int ENTRIES   = 8;
    localparam int IDX_W     = 3;
    localparam int CNT_OUT_W = 4;
    localparam int TOTAL_W   = 32;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd1;
    localparam logic [OP_W-1:0] OP_USE    = 3'd2;
    localparam logic [OP_W-1:0] OP_UNUSE  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

    typedef enum logic [2:0] {
        K_INSERT,
        K_NEXT,
        K_USE,
        K_UNUSE,
        K_LOAD,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             from_start;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]     index;
        logic                 found;
        t_status              status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [TOTAL_W-1:0]   total;
    } t_rsp;

endpackage

/* hw/rtl/smt_front.sv */
// Front end: accepts transactions, classifies the operation code and
// holds decoded commands in a two-entry queue. Depends on smt_pkg.
module smt_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [smt_pkg::OP_W-1:0]     i_operation,
    input  logic signed [VALUE_WIDTH-1:0] i_value_in,
    input  logic [smt_pkg::IDX_W-1:0]    i_index_in,
    input  logic                         i_from_start,
    output logic                         o_cmd_valid,
    output smt_pkg::t_cmd                o_cmd,
    output logic signed [VALUE_WIDTH-1:0] o_cmd_value,
    input  logic                         i_cmd_take
);
    import smt_pkg::*;

    localparam int DEPTH = 2;

    t_cmd                        r_cmd [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_val [DEPTH];
    logic                        r_wr_ptr;
    logic                        r_rd_ptr;
    logic [1:0]                  r_cnt;
    t_cmd                        dec;
    logic                        wr_en;
    logic                        rd_en;

    always_comb begin
        dec.idx        = i_index_in;
        dec.from_start = i_from_start;
        case (i_operation)
            OP_INSERT: dec.kind = K_INSERT;
            OP_NEXT:   dec.kind = K_NEXT;
            OP_USE:    dec.kind = K_USE;
            OP_UNUSE:  dec.kind = K_UNUSE;
            OP_LOAD:   dec.kind = K_LOAD;
            default:   dec.kind = K_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'(DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_cmd[r_rd_ptr];
    assign o_cmd_value = r_val[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cmd[r_wr_ptr] <= dec;
            r_val[r_wr_ptr] <= i_value_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (wr_en) r_wr_ptr <= ~r_wr_ptr;
            if (rd_en) r_rd_ptr <= ~r_rd_ptr;
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/smt_back.sv */
// Back end: the value/count table as a row of cells, executing one command
// per cycle unless result queue is full; gives its result. Uses smt_pkg.
module smt_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  smt_pkg::t_cmd                 i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_cmd_value,
    output logic                          o_cmd_take,
    input  logic                          i_rsp_full,
    output logic                          o_rsp_push,
    output smt_pkg::t_rsp                 o_rsp,
    output logic signed [VALUE_WIDTH-1:0] o_rsp_value
);
    import smt_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_val [ENTRIES];
    logic signed [VALUE_WIDTH-1:0] n_val [ENTRIES];
    logic [COUNT_WIDTH-1:0]        r_cnt [ENTRIES];
    logic [COUNT_WIDTH-1:0]        n_cnt [ENTRIES];
    logic [CNT_OUT_W-1:0]          r_used;
    logic [CNT_OUT_W-1:0]          n_used;
    logic [TOTAL_W-1:0]            r_total;
    logic [TOTAL_W-1:0]            n_total;

    logic [ENTRIES-1:0]   live;
    logic [ENTRIES-1:0]   eq;
    logic [ENTRIES-1:0]   gte;      // new value goes at or above this slot
    logic [ENTRIES-1:0]   gte_sh;
    logic [ENTRIES-1:0]   ins_pos;
    logic [ENTRIES-1:0]   hit;
    logic                 any_eq;
    logic                 tab_full;
    logic                 idx_ok;
    logic                 fire;
    logic [CNT_OUT_W-1:0] start;
    logic [COUNT_WIDTH-1:0] sel_cnt;
    logic [IDX_W-1:0]     hit_idx;

    assign fire       = i_cmd_valid && !i_rsp_full;
    assign o_cmd_take = fire;
    assign o_rsp_push = fire;
    assign sel_cnt    = r_cnt[i_cmd.idx];
    assign idx_ok     = {1'b0, i_cmd.idx} < r_used;
    assign tab_full   = (r_used == CNT_OUT_W'(ENTRIES));
    assign start      = i_cmd.from_start ? '0
                        : (CNT_OUT_W'(i_cmd.idx) + CNT_OUT_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            live[i] = CNT_OUT_W'(i) < r_used;
            eq[i]   = live[i] && (r_val[i] == i_cmd_value);
            gte[i]  = !live[i] || (i_cmd_value > r_val[i]);
            hit[i]  = live[i] && (CNT_OUT_W'(i) >= start) && (r_cnt[i] != '0);
        end
    end

    assign any_eq  = |eq;
    assign gte_sh  = {gte[ENTRIES-2:0], 1'b0};
    assign ins_pos = gte & ~gte_sh;

    // lowest set hit bit
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) hit_idx = IDX_W'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_val[i] = r_val[i];
            n_cnt[i] = r_cnt[i];
        end
        n_used            = r_used;
        n_total           = r_total;
        o_rsp_value       = '0;
        o_rsp.index       = '0;
        o_rsp.found       = 1'b0;
        o_rsp.status      = ST_OK;

        case (i_cmd.kind)
            K_INSERT: begin
                if (any_eq) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (eq[i] && r_cnt[i] != '1) n_cnt[i] = r_cnt[i] + 1'b1;
                    end
                    if (r_total != '1) n_total = r_total + 1'b1;
                end else if (tab_full) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (gte_sh[i]) begin
                            n_val[i] = r_val[i-1];
                            n_cnt[i] = r_cnt[i-1];
                        end
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ins_pos[i]) begin
                            n_val[i] = i_cmd_value;
                            n_cnt[i] = COUNT_WIDTH'(1);
                        end
                    end
                    n_used = r_used + 1'b1;
                    if (r_total != '1) n_total = r_total + 1'b1;
                end
            end
            K_NEXT: begin
                o_rsp.found = |hit;
                o_rsp.index = hit_idx;
            end
            K_USE: begin
                if (!idx_ok || sel_cnt == '0) begin
                    o_rsp.status = ST_BAD;
                end else begin
                    n_cnt[i_cmd.idx] = sel_cnt - 1'b1;
                    o_rsp_value      = r_val[i_cmd.idx];
                end
            end
            K_UNUSE: begin
                if (!idx_ok) begin
                    o_rsp.status = ST_BAD;
                end else if (sel_cnt != '1) begin
                    n_cnt[i_cmd.idx] = sel_cnt + 1'b1;
                end
            end
            K_LOAD: begin
                if (!idx_ok) o_rsp.status = ST_BAD;
                else         o_rsp_value  = r_val[i_cmd.idx];
            end
            default: begin
            end
        endcase

        o_rsp.entry_count = n_used;
        o_rsp.total       = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int i = 0; i < ENTRIES; i++) r_val[i] <= n_val[i];
        end
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) r_cnt[i] <= '0;
            r_used  <= '0;
            r_total <= '0;
        end else if (fire) begin
            for (int i = 0; i < ENTRIES; i++) r_cnt[i] <= n_cnt[i];
            r_used  <= n_used;
            r_total <= n_total;
        end
    end

endmodule

/* hw/rtl/smt_rsp_q.sv */
// Two-entry result queue between the back end and the result ports.
// Depends on smt_pkg for the result struct.
module smt_rsp_q #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  smt_pkg::t_rsp                 i_rsp,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_empty,
    output smt_pkg::t_rsp                 o_rsp,
    output logic signed [VALUE_WIDTH-1:0] o_value
);
    import smt_pkg::*;

    localparam int DEPTH = 2;

    t_rsp                          r_rsp [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_val [DEPTH];
    logic                          r_wr_ptr;
    logic                          r_rd_ptr;
    logic [1:0]                    r_cnt;
    logic                          wr_en;
    logic                          rd_en;

    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rsp   = r_rsp[r_rd_ptr];
    assign o_value = r_val[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rsp[r_wr_ptr] <= i_rsp;
            r_val[r_wr_ptr] <= i_value;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (wr_en) r_wr_ptr <= ~r_wr_ptr;
            if (rd_en) r_rd_ptr <= ~r_rd_ptr;
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/sorted_multiset_table_top.sv */
// Top level of the sorted multiset table: front end, table back end and
// result queue. Depends on smt_pkg, smt_front, smt_back and smt_rsp_q.
//
// Usage: the input side is a queue. Present operation, value, index and
// from_start with i_push; the transaction is taken on an edge where i_push
// is high and o_full is low. The result side is a queue too: while o_empty
// is low the oldest result is on the o_ ports, and it leaves on an edge
// where i_pop is high. Every input transaction yields exactly one result,
// in order.
// The command queue registers each transaction as it is taken. The back end
// executes the command at the head of that queue, comparing the value against
// all entries in parallel, and writes its result into the result queue, whose
// head is on the o_ ports.
// Throughput: one transaction per cycle while results are popped.
// Reset empties both queues, clears all counts, the entry count and the
// insert total. If the receiver stalls, the two-entry result queue fills,
// the back end stops, then the two-entry command queue fills and o_full
// rises; nothing is dropped.
module sorted_multiset_table_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [smt_pkg::OP_W-1:0]          i_operation,
    input  logic signed [VALUE_WIDTH-1:0]     i_value_in,
    input  logic [smt_pkg::IDX_W-1:0]         i_index_in,
    input  logic                              i_from_start,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic signed [VALUE_WIDTH-1:0]     o_value_out,
    output logic [smt_pkg::IDX_W-1:0]         o_index_out,
    output logic                              o_found,
    output logic [1:0]                        o_status,
    output logic [smt_pkg::CNT_OUT_W-1:0]     o_entry_count,
    output logic [smt_pkg::TOTAL_W-1:0]       o_total_inserts
);
    import smt_pkg::*;

    logic                          cmd_valid;
    t_cmd                          cmd;
    logic signed [VALUE_WIDTH-1:0] cmd_value;
    logic                          cmd_take;
    logic                          rsp_full;
    logic                          rsp_push;
    t_rsp                          rsp_in;
    logic signed [VALUE_WIDTH-1:0] rsp_in_value;
    t_rsp                          rsp_out;

    smt_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_operation  (i_operation),
        .i_value_in   (i_value_in),
        .i_index_in   (i_index_in),
        .i_from_start (i_from_start),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .o_cmd_value  (cmd_value),
        .i_cmd_take   (cmd_take)
    );

    smt_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_cmd_value (cmd_value),
        .o_cmd_take  (cmd_take),
        .i_rsp_full  (rsp_full),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp_in),
        .o_rsp_value (rsp_in_value)
    );

    smt_rsp_q #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_rsp   (rsp_in),
        .i_value (rsp_in_value),
        .o_full  (rsp_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_rsp   (rsp_out),
        .o_value (o_value_out)
    );

    assign o_index_out     = rsp_out.index;
    assign o_found         = rsp_out.found;
    assign o_status        = rsp_out.status;
    assign o_entry_count   = rsp_out.entry_count;
    assign o_total_inserts = rsp_out.total;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for sorted_multiset_table_top: queue-style driver and
// monitor, with a shadow copy of the sorted table that predicts every result.
// Depends on smt_pkg and the sorted_multiset_table_top RTL.
module tb_top;
    import smt_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int AVAIL_W     = 16;
    localparam int IDLE_PCT    = 6;
    localparam int STALL_LIMIT = 1000;
    localparam int RX_HOLD     = 150;
    localparam int RANDOM_OPS  = 800;
    localparam int SAT_UNUSES  = 30;

    // operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          index;
        logic                      from_start;
        bit                        drain;
    } table_req_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_rsp                      rsp;
    } table_result_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_push = 1'b0;
    logic                          o_full;
    logic [OP_W-1:0]               i_operation = '0;
    logic signed [VALUE_W-1:0]     i_value_in = '0;
    logic [IDX_W-1:0]              i_index_in = '0;
    logic                          i_from_start = 1'b0;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic signed [VALUE_W-1:0]     o_value_out;
    logic [IDX_W-1:0]              o_index_out;
    logic                          o_found;
    logic [1:0]                    o_status;
    logic [CNT_OUT_W-1:0]          o_entry_count;
    logic [TOTAL_W-1:0]            o_total_inserts;

    // shadow copy of the table
    logic signed [VALUE_W-1:0] tbl_value [ENTRIES];
    logic [AVAIL_W-1:0]        tbl_avail [ENTRIES];
    int                        tbl_used;
    logic [TOTAL_W-1:0]        tbl_inserts;

    table_req_t                op_backlog [$];
    table_result_t             predicted_results [$];
    logic signed [VALUE_W-1:0] inserted_vals [$];

    table_req_t    taken;
    table_req_t    cur;
    table_result_t want;
    logic          push_next;
    bit            op_taken;
    bit            hold_done;
    int            hold_left;
    int            n_queued;
    int            items_taken;
    int            results_seen;
    int            idle_cycles;
    int            full_stall_cycles;
    int            errors;
    int            n_full;
    int            n_bad;
    int            n_hits;
    int            calm_lo;
    int            calm_hi;
    int            hold_at;

    sorted_multiset_table_top #(
        .VALUE_WIDTH(VALUE_W),
        .COUNT_WIDTH(AVAIL_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_operation    (i_operation),
        .i_value_in     (i_value_in),
        .i_index_in     (i_index_in),
        .i_from_start   (i_from_start),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_value_out    (o_value_out),
        .o_index_out    (o_index_out),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_total_inserts(o_total_inserts)
    );

    always #5 i_clk = ~i_clk;

    function automatic table_result_t apply_table_op(input table_req_t req);
        table_result_t res;
        int            pos;
        int            start;
        bit            hit;
        bit            stop;
        bit            idx_ok;
        res.value = '0;
        res.rsp   = '0;
        res.rsp.status = ST_OK;
        idx_ok = req.index < tbl_used;
        case (req.op)
            OP_INSERT: begin
                pos  = tbl_used;
                hit  = 1'b0;
                stop = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!stop && i < tbl_used) begin
                        if (tbl_value[i] == req.value) begin
                            hit  = 1'b1;
                            pos  = i;
                            stop = 1'b1;
                        end else if (req.value > tbl_value[i]) begin
                            pos  = i;
                            stop = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    if (tbl_avail[pos] != '1)
                        tbl_avail[pos] = tbl_avail[pos] + 1'b1;
                end else if (tbl_used >= ENTRIES) begin
                    res.rsp.status = ST_FULL;
                end else begin
                    // open a slot at pos by moving the smaller entries down
                    for (int i = ENTRIES - 1; i > 0; i--) begin
                        if (i > pos && i <= tbl_used) begin
                            tbl_value[i] = tbl_value[i-1];
                            tbl_avail[i] = tbl_avail[i-1];
                        end
                    end
                    tbl_value[pos] = req.value;
                    tbl_avail[pos] = AVAIL_W'(1);
                    tbl_used++;
                end
                if (res.rsp.status == ST_OK && tbl_inserts != '1)
                    tbl_inserts = tbl_inserts + 1'b1;
            end
            OP_NEXT: begin
                start = req.from_start ? 0 : int'(req.index) + 1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!res.rsp.found && i >= start && i < tbl_used && tbl_avail[i] != 0) begin
                        res.rsp.found = 1'b1;
                        res.rsp.index = IDX_W'(i);
                    end
                end
            end
            OP_USE: begin
                if (!idx_ok || tbl_avail[req.index] == 0) begin
                    res.rsp.status = ST_BAD;
                end else begin
                    tbl_avail[req.index] = tbl_avail[req.index] - 1'b1;
                    res.value = tbl_value[req.index];
                end
            end
            OP_UNUSE: begin
                if (!idx_ok)
                    res.rsp.status = ST_BAD;
                else if (tbl_avail[req.index] != '1)
                    tbl_avail[req.index] = tbl_avail[req.index] + 1'b1;
            end
            OP_LOAD: begin
                if (!idx_ok)
                    res.rsp.status = ST_BAD;
                else
                    res.value = tbl_value[req.index];
            end
            default: ;
        endcase
        res.rsp.entry_count = CNT_OUT_W'(tbl_used);
        res.rsp.total       = tbl_inserts;
        return res;
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                            input logic [IDX_W-1:0] index, input logic from_start);
        table_req_t req;
        req.op         = op;
        req.value      = value;
        req.index      = index;
        req.from_start = from_start;
        req.drain      = 1'b0;
        op_backlog.push_back(req);
        if (op == OP_INSERT)
            inserted_vals.push_back(value);
        n_queued++;
    endtask

    task automatic queue_drain();
        table_req_t req;
        req       = '{default: '0};
        req.drain = 1'b1;
        op_backlog.push_back(req);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    function automatic bit quiet_window(input int n);
        return n >= calm_lo && n < calm_hi;
    endfunction

    // input side: present the next pending transaction at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            push_next = i_push && !op_taken;
            op_taken  = 1'b0;
            if (!push_next && op_backlog.size() > 0) begin
                if (op_backlog[0].drain) begin
                    if (predicted_results.size() == 0)
                        void'(op_backlog.pop_front());
                end else if (quiet_window(items_taken) ||
                             $urandom_range(0, 99) >= IDLE_PCT) begin
                    cur = op_backlog.pop_front();
                    i_operation  <= cur.op;
                    i_value_in   <= cur.value;
                    i_index_in   <= cur.index;
                    i_from_start <= cur.from_start;
                    push_next = 1'b1;
                end
            end
            i_push <= push_next;
        end
    end

    // result side: random pop gaps plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left == 0 && !hold_done && results_seen >= hold_at) begin
                hold_left = RX_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= quiet_window(results_seen) || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_push && o_full)
                full_stall_cycles++;
            if (i_push && !o_full) begin
                taken.op         = i_operation;
                taken.value      = i_value_in;
                taken.index      = i_index_in;
                taken.from_start = i_from_start;
                taken.drain      = 1'b0;
                predicted_results.push_back(apply_table_op(taken));
                op_taken    = 1'b1;
                items_taken++;
                idle_cycles = 0;
            end
            if (i_pop && !o_empty) begin
                results_seen++;
                idle_cycles = 0;
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, value %0h status %0d",
                             $time, o_value_out, o_status);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    if (want.rsp.status == ST_FULL)
                        n_full++;
                    if (want.rsp.status == ST_BAD)
                        n_bad++;
                    if (want.rsp.found)
                        n_hits++;
                    check_field("value_out", want.value, o_value_out);
                    check_field("index_out", 32'(want.rsp.index), 32'(o_index_out));
                    check_field("found", 32'(want.rsp.found), 32'(o_found));
                    check_field("status", 32'(want.rsp.status), 32'(o_status));
                    check_field("entry_count", 32'(want.rsp.entry_count),
                                32'(o_entry_count));
                    check_field("total_inserts", want.rsp.total, o_total_inserts);
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("sorted_multiset_table_top regression: fail");
        $finish;
    end

    initial begin
        int                        base;
        int                        pick;
        logic signed [VALUE_W-1:0] v;
        logic [OP_W-1:0]           op;

        tbl_used    = 0;
        tbl_inserts = '0;
        for (int i = 0; i < ENTRIES; i++)
            tbl_avail[i] = '0;

        // empty table: no hits, every index out of range, reserved codes
        queue_op(OP_NEXT, $urandom, 0, 1'b1);
        queue_op(OP_LOAD, $urandom, 0, 1'b0);
        queue_op(OP_USE, $urandom, 7, 1'b1);
        queue_op(OP_UNUSE, $urandom, 3, 1'b0);
        queue_op(OP_RSVD_FIRST, $urandom, 5, 1'b1);
        queue_op(OP_RSVD_LAST, $urandom, 2, 1'b0);
        // inserts at head, tail and middle, plus a duplicate
        queue_op(OP_INSERT, 0, 0, 1'b0);
        queue_op(OP_INSERT, 32'sh7fffffff, 7, 1'b1);
        queue_op(OP_INSERT, 32'sh80000000, 0, 1'b0);
        queue_op(OP_INSERT, 0, 0, 1'b0);
        queue_op(OP_INSERT, -1, 0, 1'b0);
        queue_op(OP_INSERT, 1, 0, 1'b0);
        // table is now max, 1, 0, -1, min
        queue_op(OP_LOAD, $urandom, 4, 1'b0);
        queue_op(OP_USE, $urandom, 0, 1'b0);
        queue_op(OP_USE, $urandom, 0, 1'b0);
        queue_op(OP_NEXT, $urandom, 6, 1'b1);
        queue_op(OP_NEXT, $urandom, 0, 1'b0);
        queue_op(OP_NEXT, $urandom, 4, 1'b0);
        queue_op(OP_NEXT, $urandom, 7, 1'b0);
        queue_op(OP_UNUSE, $urandom, 0, 1'b0);
        queue_op(OP_LOAD, $urandom, 5, 1'b1);
        queue_op(OP_LOAD, $urandom, 7, 1'b0);
        queue_drain();

        // pile up the count of value 0 (entry 2), then bump and use it
        repeat (SAT_UNUSES)
            queue_op(OP_UNUSE, $urandom, 2, 1'($urandom_range(0, 1)));
        queue_op(OP_INSERT, 0, 2, 1'b0);
        queue_op(OP_USE, $urandom, 2, 1'b0);
        queue_drain();

        base    = n_queued;
        hold_at = base + 100;
        calm_lo = base + 300;
        calm_hi = base + 500;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            v    = $urandom;
            if (pick < 25) begin
                op = OP_INSERT;
                case ($urandom_range(0, 3))
                    0, 1: v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
                    2: v = int'($urandom_range(0, 40)) - 20;
                    default: ;
                endcase
            end else if (pick < 45) begin
                op = OP_NEXT;
            end else if (pick < 70) begin
                op = OP_USE;
            end else if (pick < 85) begin
                op = OP_UNUSE;
            end else if (pick < 95) begin
                op = OP_LOAD;
            end else begin
                op = OP_W'(OP_RSVD_FIRST + $urandom_range(0, OP_RSVD_LAST - OP_RSVD_FIRST));
            end
            queue_op(op, v, IDX_W'($urandom_range(0, ENTRIES - 1)),
                     1'($urandom_range(0, 1)));
            if (n == 425)
                queue_drain();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || i_push || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d transactions in, %0d results checked: %0d table full, %0d bad index",
                 items_taken, results_seen, n_full, n_bad);
        $display("next hits %0d, input held off by full for %0d cycles, %0d mismatches",
                 n_hits, full_stall_cycles, errors);
        if (errors == 0)
            $display("sorted_multiset_table_top regression: pass");
        else
            $display("sorted_multiset_table_top regression: fail");
        $finish;
    end

endmodule
